FILE: rtl/core/pms_pkg.sv
// Package for the pendulum mode supervisor: state, mode, event and drive codes,
// configuration constants and the tick and result structs.
// No dependencies; imported by every module of the block.
`default_nettype none

package pms_pkg;

    // Field widths
    localparam int STATE_W  = 2;
    localparam int MODE_W   = 2;
    localparam int EVENT_W  = 4;
    localparam int DRIVE_W  = 3;
    localparam int CHAR_W   = 8;
    localparam int ANGLE_W  = 16;
    localparam int LIMIT_W  = 15;
    localparam int CFG_IDX_W = 1;

    // Run states
    localparam logic [STATE_W-1:0] ST_IDLE     = 2'd0;
    localparam logic [STATE_W-1:0] ST_RUNNING  = 2'd1;
    localparam logic [STATE_W-1:0] ST_JOYSTICK = 2'd2;
    localparam logic [STATE_W-1:0] ST_SWINGUP  = 2'd3;

    // Operating modes
    localparam logic [MODE_W-1:0] MD_IDLE   = 2'd0;
    localparam logic [MODE_W-1:0] MD_AUTO   = 2'd1;
    localparam logic [MODE_W-1:0] MD_ASSIST = 2'd2;
    localparam logic [MODE_W-1:0] MD_JOY    = 2'd3;

    // Events, in rule order
    localparam logic [EVENT_W-1:0] EV_NONE         = 4'd0;
    localparam logic [EVENT_W-1:0] EV_START        = 4'd1;
    localparam logic [EVENT_W-1:0] EV_STOP         = 4'd2;
    localparam logic [EVENT_W-1:0] EV_JOY_ON       = 4'd3;
    localparam logic [EVENT_W-1:0] EV_JOY_OFF      = 4'd4;
    localparam logic [EVENT_W-1:0] EV_SWING_ON     = 4'd5;
    localparam logic [EVENT_W-1:0] EV_SWING_OFF    = 4'd6;
    localparam logic [EVENT_W-1:0] EV_MODE_AUTO    = 4'd7;
    localparam logic [EVENT_W-1:0] EV_MODE_ASSIST  = 4'd8;
    localparam logic [EVENT_W-1:0] EV_MODE_JOY     = 4'd9;
    localparam logic [EVENT_W-1:0] EV_MODE_IDLE    = 4'd10;
    localparam logic [EVENT_W-1:0] EV_ESTOP        = 4'd11;
    localparam logic [EVENT_W-1:0] EV_CAPTURE      = 4'd12;
    localparam logic [EVENT_W-1:0] EV_CRASH_SWING  = 4'd13;
    localparam logic [EVENT_W-1:0] EV_CRASH_JOY    = 4'd14;
    localparam logic [EVENT_W-1:0] EV_CRASH_IDLE   = 4'd15;

    // Actuator sources
    localparam logic [DRIVE_W-1:0] DRV_COAST    = 3'd0;
    localparam logic [DRIVE_W-1:0] DRV_LQR      = 3'd1;
    localparam logic [DRIVE_W-1:0] DRV_STICK    = 3'd2;
    localparam logic [DRIVE_W-1:0] DRV_JOYSTICK = 3'd3;
    localparam logic [DRIVE_W-1:0] DRV_SWINGUP  = 3'd4;

    // Serial command bytes
    localparam logic [CHAR_W-1:0] CMD_START = 8'h77;  // 'w'
    localparam logic [CHAR_W-1:0] CMD_STOP  = 8'h73;  // 's'
    localparam logic [CHAR_W-1:0] CMD_JOY   = 8'h6A;  // 'j'
    localparam logic [CHAR_W-1:0] CMD_SWING = 8'h75;  // 'u'

    // Configuration register indexes and reset values (unsigned Q3.12)
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRASH_LIMIT   = 1'd1;
    localparam logic [LIMIT_W-1:0]   CAPTURE_LIMIT_RST = 15'd819;   // 0.2 rad
    localparam logic [LIMIT_W-1:0]   CRASH_LIMIT_RST   = 15'd6434;  // pi/2 rad

    typedef struct packed {
        logic                      serial_valid;
        logic [CHAR_W-1:0]         serial_char;
        logic                      press_a;
        logic                      press_b;
        logic                      press_y;
        logic                      press_x;
        logic                      hold_l1;
        logic                      hold_r1;
        logic                      stick_link_ok;
        logic signed [ANGLE_W-1:0] phi_angle;
    } tick_t;

    typedef struct packed {
        logic [STATE_W-1:0] ctrl_state;
        logic [MODE_W-1:0]  ctrl_mode;
        logic [EVENT_W-1:0] event_code;
        logic               enter_swingup;
        logic               reset_reference;
        logic               restart_timer;
        logic [DRIVE_W-1:0] drive_source;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/pms_in_reg.sv
// Input register of the pendulum mode supervisor: captures one tick per transfer.
// Depends on pms_pkg for tick_t.
`default_nettype none

module pms_in_reg
    import pms_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire tick_t tick_in,
    input  wire logic  advance,
    output logic       tick_valid,
    output tick_t      tick
);

    logic  valid_reg;
    logic  valid_next;
    tick_t tick_reg;

    // Accept when empty or when the held tick moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload until the next transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tick_reg <= tick_in;
        end
    end

    assign tick_valid = valid_reg;
    assign tick       = tick_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pms_decide.sv
// Decision logic of the pendulum mode supervisor: limit registers, run state,
// operating mode and the per-tick rule chain. Depends on pms_pkg.
`default_nettype none

module pms_decide
    import pms_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LIMIT_W-1:0]   cfg_data,
    input  wire logic                 step,
    input  wire tick_t                tick,
    output result_t                   result
);

    logic [LIMIT_W-1:0] capture_limit_reg;
    logic [LIMIT_W-1:0] crash_limit_reg;
    logic [STATE_W-1:0] run_state_reg;
    logic [STATE_W-1:0] run_state_next;
    logic [MODE_W-1:0]  op_mode_reg;
    logic [MODE_W-1:0]  op_mode_next;

    logic [ANGLE_W-1:0] mag;
    logic               is_cmd;
    logic [STATE_W-1:0] st_a;
    logic [STATE_W-1:0] st_b;
    logic [MODE_W-1:0]  md_b;
    logic [STATE_W-1:0] st_c;
    logic [EVENT_W-1:0] ev_a;
    logic [EVENT_W-1:0] ev_b;
    logic [EVENT_W-1:0] ev_c;
    logic               swing;
    logic               capture;
    logic               crash;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_limit_reg <= CAPTURE_LIMIT_RST;
            crash_limit_reg   <= CRASH_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAPTURE_LIMIT: capture_limit_reg <= cfg_data;
                CFG_CRASH_LIMIT:   crash_limit_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Angle magnitude; the most negative angle maps to 32768
    assign mag = tick.phi_angle[ANGLE_W-1] ? (~tick.phi_angle + 16'd1) : tick.phi_angle;

    // Serial commands
    assign is_cmd = tick.serial_valid;
    always_comb
    begin
        st_a = run_state_reg;
        ev_a = EV_NONE;
        if (is_cmd && tick.serial_char == CMD_START && run_state_reg == ST_IDLE)
        begin
            st_a = ST_RUNNING;
            ev_a = EV_START;
        end
        else if (is_cmd && tick.serial_char == CMD_STOP && run_state_reg == ST_RUNNING)
        begin
            st_a = ST_IDLE;
            ev_a = EV_STOP;
        end
        else if (is_cmd && tick.serial_char == CMD_JOY && run_state_reg == ST_IDLE)
        begin
            st_a = ST_JOYSTICK;
            ev_a = EV_JOY_ON;
        end
        else if (is_cmd && tick.serial_char == CMD_JOY && run_state_reg == ST_JOYSTICK)
        begin
            st_a = ST_IDLE;
            ev_a = EV_JOY_OFF;
        end
        else if (is_cmd && tick.serial_char == CMD_SWING && run_state_reg == ST_IDLE)
        begin
            st_a = ST_SWINGUP;
            ev_a = EV_SWING_ON;
        end
        else if (is_cmd && tick.serial_char == CMD_SWING && run_state_reg == ST_SWINGUP)
        begin
            st_a = ST_IDLE;
            ev_a = EV_SWING_OFF;
        end
    end

    // Button mode changes, then the two-shoulder emergency stop; last wins
    always_comb
    begin
        st_b = st_a;
        md_b = op_mode_reg;
        ev_b = ev_a;
        if (tick.press_a)
        begin
            md_b = MD_AUTO;
            st_b = ST_SWINGUP;
            ev_b = EV_MODE_AUTO;
        end
        if (tick.press_b)
        begin
            md_b = MD_ASSIST;
            st_b = ST_JOYSTICK;
            ev_b = EV_MODE_ASSIST;
        end
        if (tick.press_y)
        begin
            md_b = MD_JOY;
            st_b = ST_JOYSTICK;
            ev_b = EV_MODE_JOY;
        end
        if (tick.press_x)
        begin
            md_b = MD_IDLE;
            st_b = ST_IDLE;
            ev_b = EV_MODE_IDLE;
        end
        if (tick.hold_l1 && tick.hold_r1 && st_b != ST_IDLE)
        begin
            md_b = MD_IDLE;
            st_b = ST_IDLE;
            ev_b = EV_ESTOP;
        end
    end

    // Capture into balance near upright
    assign capture = (st_b == ST_JOYSTICK || st_b == ST_SWINGUP)
                     && (mag < {1'b0, capture_limit_reg});
    assign st_c    = capture ? ST_RUNNING : st_b;
    assign ev_c    = capture ? EV_CAPTURE : ev_b;
    assign crash   = (st_c == ST_RUNNING) && (mag > {1'b0, crash_limit_reg});

    // Crash recovery and actuator selection
    always_comb
    begin
        run_state_next = st_c;
        op_mode_next   = md_b;
        result.event_code   = ev_c;
        result.drive_source = DRV_COAST;
        swing = tick.press_a || ev_a == EV_SWING_ON;
        if (crash)
        begin
            result.drive_source = DRV_COAST;
            priority case (md_b)
                MD_AUTO:
                begin
                    run_state_next    = ST_SWINGUP;
                    result.event_code = EV_CRASH_SWING;
                    swing             = 1'b1;
                end
                MD_ASSIST:
                begin
                    run_state_next    = ST_JOYSTICK;
                    result.event_code = EV_CRASH_JOY;
                end
                default:
                begin
                    run_state_next    = ST_IDLE;
                    result.event_code = EV_CRASH_IDLE;
                end
            endcase
        end
        else
        begin
            unique case (st_c)
                ST_RUNNING:
                begin
                    if (md_b == MD_ASSIST && tick.hold_r1 && tick.stick_link_ok)
                    begin
                        result.drive_source = DRV_STICK;
                    end
                    else
                    begin
                        result.drive_source = DRV_LQR;
                    end
                end
                ST_IDLE:     result.drive_source = DRV_COAST;
                ST_JOYSTICK: result.drive_source = DRV_JOYSTICK;
                ST_SWINGUP:  result.drive_source = DRV_SWINGUP;
                default:     result.drive_source = DRV_COAST;
            endcase
        end
        result.ctrl_state      = run_state_next;
        result.ctrl_mode       = op_mode_next;
        result.enter_swingup   = swing;
        result.reset_reference = capture;
        result.restart_timer   = capture || ev_a == EV_START;
    end

    // Advance state once per tick transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_state_reg <= ST_IDLE;
            op_mode_reg   <= MD_IDLE;
        end
        else if (step)
        begin
            run_state_reg <= run_state_next;
            op_mode_reg   <= op_mode_next;
        end
    end

    // Checks
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(run_state_reg) && $stable(op_mode_reg))
        else $error("state changed without a tick");

    a_swing_event: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.enter_swingup |-> (ev_a == EV_SWING_ON || tick.press_a
            || result.event_code == EV_CRASH_SWING))
        else $error("swing-up pulse without a swing-up event");

    a_ref_timer: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.reset_reference |-> result.restart_timer)
        else $error("reference clear without timer restart");

    a_crash_coast: assert property (@(posedge clk) disable iff (!rst_n)
        step && crash |-> result.drive_source == DRV_COAST
            && result.ctrl_state != ST_RUNNING)
        else $error("crash tick does not coast");

    a_mode_follows: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> op_mode_reg == $past(result.ctrl_mode)
            && run_state_reg == $past(result.ctrl_state))
        else $error("stored state differs from reported state");

endmodule

`default_nettype wire

FILE: rtl/core/pms_out_reg.sv
// Result register of the pendulum mode supervisor: holds one result until its
// transfer completes. Depends on pms_pkg for result_t.
`default_nettype none

module pms_out_reg
    import pms_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t result_in,
    output logic         can_load,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Room when empty or when the held result leaves this cycle
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pendulum_mode_supervisor_core.sv
// Pendulum mode supervisor: per-tick run state and mode control.
// A tick is held in the input register, then its result in the result register.
// One tick per cycle while out_ready is high; the rule chain is one combinational pass.
// Reset (rst_n low, asynchronous): state idle, mode idle, limits 819 and 6434,
// both stages empty. Depends on pms_pkg, pms_in_reg, pms_decide, pms_out_reg.
`default_nettype none

module pendulum_mode_supervisor_core
    import pms_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [LIMIT_W-1:0]          cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        serial_valid,
    input  wire logic [CHAR_W-1:0]           serial_char,
    input  wire logic                        press_a,
    input  wire logic                        press_b,
    input  wire logic                        press_y,
    input  wire logic                        press_x,
    input  wire logic                        hold_l1,
    input  wire logic                        hold_r1,
    input  wire logic                        stick_link_ok,
    input  wire logic signed [ANGLE_W-1:0]   phi_angle,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [STATE_W-1:0]               ctrl_state,
    output logic [MODE_W-1:0]                ctrl_mode,
    output logic [EVENT_W-1:0]               event_code,
    output logic                             enter_swingup,
    output logic                             reset_reference,
    output logic                             restart_timer,
    output logic [DRIVE_W-1:0]               drive_source
);

    tick_t   tick_in;
    tick_t   tick;
    logic    tick_valid;
    logic    can_load;
    logic    advance;
    result_t result_c;
    result_t result_q;

    // Pack the input fields
    assign tick_in.serial_valid  = serial_valid;
    assign tick_in.serial_char   = serial_char;
    assign tick_in.press_a       = press_a;
    assign tick_in.press_b       = press_b;
    assign tick_in.press_y       = press_y;
    assign tick_in.press_x       = press_x;
    assign tick_in.hold_l1       = hold_l1;
    assign tick_in.hold_r1       = hold_r1;
    assign tick_in.stick_link_ok = stick_link_ok;
    assign tick_in.phi_angle     = phi_angle;

    // Move a held tick into the result register when there is room
    assign advance = tick_valid && can_load;

    pms_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .tick_in    (tick_in),
        .advance    (advance),
        .tick_valid (tick_valid),
        .tick       (tick)
    );

    pms_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (advance),
        .tick      (tick),
        .result    (result_c)
    );

    pms_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result_in (result_c),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result_q)
    );

    // Unpack the result fields
    assign ctrl_state      = result_q.ctrl_state;
    assign ctrl_mode       = result_q.ctrl_mode;
    assign event_code      = result_q.event_code;
    assign enter_swingup   = result_q.enter_swingup;
    assign reset_reference = result_q.reset_reference;
    assign restart_timer   = result_q.restart_timer;
    assign drive_source    = result_q.drive_source;

endmodule

`default_nettype wire

FILE: tb/mode_supervisor_checker.sv
// Result checker for the pendulum mode supervisor: follows limit writes, predicts
// the result of every tick transfer and compares it with the result transfers.
// Depends on pms_pkg.

module mode_supervisor_checker
    import pms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0]   cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  tick_t                tick,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  result_t              seen,
    output int                   fail_count,
    output int                   pending
);

    logic [LIMIT_W-1:0] capture_lim = CAPTURE_LIMIT_RST;
    logic [LIMIT_W-1:0] crash_lim   = CRASH_LIMIT_RST;
    logic [STATE_W-1:0] run_st      = ST_IDLE;
    logic [MODE_W-1:0]  op_md       = MD_IDLE;
    result_t            due_results[$];
    int                 fails = 0;

    // Apply the rule chain of one tick to the tracked state and mode
    function automatic result_t supervise_tick(input tick_t t);
        result_t            r;
        logic [ANGLE_W:0]   mag;
        logic [STATE_W-1:0] st;
        logic [MODE_W-1:0]  md;
        r   = '0;
        st  = run_st;
        md  = op_md;
        mag = t.phi_angle[ANGLE_W-1] ? {1'b0, ~t.phi_angle} + 1'b1 : {1'b0, t.phi_angle};

        // serial commands, each only in its own state
        if (t.serial_valid)
        begin
            if (t.serial_char == CMD_START && st == ST_IDLE)
            begin
                st = ST_RUNNING;
                r.event_code = EV_START;
                r.restart_timer = 1'b1;
            end
            if (t.serial_char == CMD_STOP && st == ST_RUNNING)
            begin
                st = ST_IDLE;
                r.event_code = EV_STOP;
            end
            if (t.serial_char == CMD_JOY && st == ST_IDLE)
            begin
                st = ST_JOYSTICK;
                r.event_code = EV_JOY_ON;
            end
            else if (t.serial_char == CMD_JOY && st == ST_JOYSTICK)
            begin
                st = ST_IDLE;
                r.event_code = EV_JOY_OFF;
            end
            if (t.serial_char == CMD_SWING && st == ST_IDLE)
            begin
                st = ST_SWINGUP;
                r.event_code = EV_SWING_ON;
                r.enter_swingup = 1'b1;
            end
            else if (t.serial_char == CMD_SWING && st == ST_SWINGUP)
            begin
                st = ST_IDLE;
                r.event_code = EV_SWING_OFF;
            end
        end

        // button mode changes, later buttons win
        if (t.press_a)
        begin
            md = MD_AUTO;
            st = ST_SWINGUP;
            r.event_code = EV_MODE_AUTO;
            r.enter_swingup = 1'b1;
        end
        if (t.press_b)
        begin
            md = MD_ASSIST;
            st = ST_JOYSTICK;
            r.event_code = EV_MODE_ASSIST;
        end
        if (t.press_y)
        begin
            md = MD_JOY;
            st = ST_JOYSTICK;
            r.event_code = EV_MODE_JOY;
        end
        if (t.press_x)
        begin
            md = MD_IDLE;
            st = ST_IDLE;
            r.event_code = EV_MODE_IDLE;
        end

        // emergency stop on both shoulders
        if (t.hold_l1 && t.hold_r1 && st != ST_IDLE)
        begin
            md = MD_IDLE;
            st = ST_IDLE;
            r.event_code = EV_ESTOP;
        end

        // capture into balance near upright
        if ((st == ST_JOYSTICK || st == ST_SWINGUP) && mag < capture_lim)
        begin
            st = ST_RUNNING;
            r.event_code = EV_CAPTURE;
            r.restart_timer = 1'b1;
            r.reset_reference = 1'b1;
        end

        // crash recovery and actuator source
        r.drive_source = DRV_COAST;
        if (st == ST_RUNNING)
        begin
            if (mag > crash_lim)
            begin
                if (md == MD_AUTO)
                begin
                    st = ST_SWINGUP;
                    r.event_code = EV_CRASH_SWING;
                    r.enter_swingup = 1'b1;
                end
                else if (md == MD_ASSIST)
                begin
                    st = ST_JOYSTICK;
                    r.event_code = EV_CRASH_JOY;
                end
                else
                begin
                    st = ST_IDLE;
                    r.event_code = EV_CRASH_IDLE;
                end
            end
            else if (md == MD_ASSIST && t.hold_r1)
            begin
                r.drive_source = t.stick_link_ok ? DRV_STICK : DRV_LQR;
            end
            else
            begin
                r.drive_source = DRV_LQR;
            end
        end
        else if (st == ST_JOYSTICK)
        begin
            r.drive_source = DRV_JOYSTICK;
        end
        else if (st == ST_SWINGUP)
        begin
            r.drive_source = DRV_SWINGUP;
        end

        r.ctrl_state = st;
        r.ctrl_mode  = md;
        run_st = st;
        op_md  = md;
        return r;
    endfunction

    // Track limits, queue predictions and check each result transfer
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            capture_lim = CAPTURE_LIMIT_RST;
            crash_lim   = CRASH_LIMIT_RST;
            run_st      = ST_IDLE;
            op_md       = MD_IDLE;
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_CAPTURE_LIMIT)
                    capture_lim = cfg_data;
                else if (cfg_index == CFG_CRASH_LIMIT)
                    crash_lim = cfg_data;
            end

            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("[%0t] result transfer with no tick outstanding: %p",
                                 $realtime, seen);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (seen.ctrl_state !== want.ctrl_state
                        || seen.ctrl_mode !== want.ctrl_mode
                        || seen.event_code !== want.event_code
                        || seen.enter_swingup !== want.enter_swingup
                        || seen.reset_reference !== want.reset_reference
                        || seen.restart_timer !== want.restart_timer
                        || seen.drive_source !== want.drive_source)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display({"[%0t] result mismatch (exp/got): state %0d/%0d ",
                                      "mode %0d/%0d event %0d/%0d swing %0b/%0b ",
                                      "refclr %0b/%0b timer %0b/%0b drive %0d/%0d"},
                                     $realtime, want.ctrl_state, seen.ctrl_state,
                                     want.ctrl_mode, seen.ctrl_mode,
                                     want.event_code, seen.event_code,
                                     want.enter_swingup, seen.enter_swingup,
                                     want.reset_reference, seen.reset_reference,
                                     want.restart_timer, seen.restart_timer,
                                     want.drive_source, seen.drive_source);
                    end
                end
            end

            if (in_valid && in_ready)
                due_results.push_back(supervise_tick(tick));

            pending <= due_results.size();
        end
        fail_count <= fails;
    end

endmodule

FILE: tb/tb.sv
// Top of the pendulum mode supervisor bench: clock, reset, tick stimulus, limit
// writes and result back-pressure around pendulum_mode_supervisor_core.
// Depends on pms_pkg, pendulum_mode_supervisor_core and mode_supervisor_checker.

module tb;
    import pms_pkg::*;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_CAPTURE_LIMIT;
    logic [LIMIT_W-1:0]   cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    tick_t                cur_tick  = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STATE_W-1:0]   ctrl_state;
    logic [MODE_W-1:0]    ctrl_mode;
    logic [EVENT_W-1:0]   event_code;
    logic                 enter_swingup;
    logic                 reset_reference;
    logic                 restart_timer;
    logic [DRIVE_W-1:0]   drive_source;
    result_t              seen;
    int                   fail_count;
    int                   pending;
    int                   accepted  = 0;
    logic [LIMIT_W-1:0]   cap_lim   = CAPTURE_LIMIT_RST;
    logic [LIMIT_W-1:0]   crash_lim = CRASH_LIMIT_RST;

    always #6 clk = ~clk;

    pendulum_mode_supervisor_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .serial_valid    (cur_tick.serial_valid),
        .serial_char     (cur_tick.serial_char),
        .press_a         (cur_tick.press_a),
        .press_b         (cur_tick.press_b),
        .press_y         (cur_tick.press_y),
        .press_x         (cur_tick.press_x),
        .hold_l1         (cur_tick.hold_l1),
        .hold_r1         (cur_tick.hold_r1),
        .stick_link_ok   (cur_tick.stick_link_ok),
        .phi_angle       (cur_tick.phi_angle),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .ctrl_state      (ctrl_state),
        .ctrl_mode       (ctrl_mode),
        .event_code      (event_code),
        .enter_swingup   (enter_swingup),
        .reset_reference (reset_reference),
        .restart_timer   (restart_timer),
        .drive_source    (drive_source)
    );

    assign seen = {ctrl_state, ctrl_mode, event_code, enter_swingup,
                   reset_reference, restart_timer, drive_source};

    mode_supervisor_checker result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .tick       (cur_tick),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .seen       (seen),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic tick_t tick_of(input logic sv, input logic [CHAR_W-1:0] ch,
                                      input logic pa, input logic pb, input logic py,
                                      input logic px, input logic l1, input logic r1,
                                      input logic link, input logic signed [ANGLE_W-1:0] phi);
        tick_t t;
        t = {sv, ch, pa, pb, py, px, l1, r1, link, phi};
        return t;
    endfunction

    // Bias angles toward both limits and the ends of the range
    function automatic logic signed [ANGLE_W-1:0] random_angle();
        int m;
        case ($urandom_range(9))
            0, 1:    m = int'(cap_lim) + int'($urandom_range(6)) - 3;
            2, 3:    m = int'(crash_lim) + int'($urandom_range(6)) - 3;
            4:
            begin
                case ($urandom_range(4))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return 16'sh0000;
                    3:       return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
            5:       m = int'($urandom_range(cap_lim));
            default: return ANGLE_W'($urandom());
        endcase
        if (m > 32767)
            m = 32767;
        if (m < 0)
            m = 0;
        return ANGLE_W'($urandom_range(1) ? -m : m);
    endfunction

    // Mostly command traffic with sparse presses, some fully random noise
    function automatic tick_t random_tick();
        tick_t t;
        if ($urandom_range(99) < 10)
        begin
            t = $urandom();
            return t;
        end
        t = '0;
        t.serial_valid = $urandom_range(99) < 40;
        case ($urandom_range(7))
            0, 1:    t.serial_char = CMD_START;
            2:       t.serial_char = CMD_STOP;
            3, 4:    t.serial_char = CMD_JOY;
            5, 6:    t.serial_char = CMD_SWING;
            default: t.serial_char = CHAR_W'($urandom());
        endcase
        t.press_a       = $urandom_range(99) < 6;
        t.press_b       = $urandom_range(99) < 6;
        t.press_y       = $urandom_range(99) < 6;
        t.press_x       = $urandom_range(99) < 5;
        t.hold_l1       = $urandom_range(99) < 20;
        t.hold_r1       = $urandom_range(99) < 35;
        t.stick_link_ok = 1'($urandom_range(1));
        t.phi_angle     = random_angle();
        return t;
    endfunction

    // Offer one tick, with optional idle cycles first, and hold it until the transfer
    task automatic send_tick(input tick_t t, input bit may_idle);
        while (may_idle && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        cur_tick <= t;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        accepted++;
    endtask

    // Drain all results, then write both limits
    task automatic write_limits(input logic [LIMIT_W-1:0] cap, input logic [LIMIT_W-1:0] crash);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CAPTURE_LIMIT;
        cfg_data  <= cap;
        @(posedge clk);
        cfg_index <= CFG_CRASH_LIMIT;
        cfg_data  <= crash;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cap_lim   = cap;
        crash_lim = crash;
    endtask

    // Result side: random stalls, one long hold-off, one stall-free stretch
    initial
    begin : result_side
        int  cyc;
        bit  held;
        cyc  = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (!held && accepted >= 250)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (80) @(posedge clk);
            end
            out_ready <= (cyc >= 700 && cyc < 1000) ? 1'b1 : ($urandom_range(99) >= 10);
        end
    end

    initial
    begin : stimulus
        int ph;
        int waited;
        waited = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed ticks at reset limits
        send_tick(tick_of(0, 8'h00, 0, 0, 0, 0, 0, 0, 0, 16'sd0), 0);
        send_tick(tick_of(1, CMD_START, 0, 0, 0, 0, 0, 0, 0, 16'sd0), 0);
        send_tick(tick_of(1, CMD_START, 0, 0, 0, 0, 0, 0, 0, 16'sd0), 0);
        send_tick(tick_of(1, CMD_STOP, 0, 0, 0, 0, 0, 0, 0, 16'sd0), 0);
        send_tick(tick_of(1, CMD_JOY, 0, 0, 0, 0, 0, 0, 0, 16'sd4000), 0);
        send_tick(tick_of(1, CMD_JOY, 0, 0, 0, 0, 0, 0, 0, 16'sd4000), 0);
        send_tick(tick_of(1, CMD_SWING, 0, 0, 0, 0, 0, 0, 0, 16'sd4000), 0);
        send_tick(tick_of(1, CMD_SWING, 0, 0, 0, 0, 0, 0, 0, 16'sd4000), 0);
        // command byte without its valid flag, then unknown bytes
        send_tick(tick_of(0, CMD_START, 0, 0, 0, 0, 0, 0, 0, 16'sd0), 0);
        send_tick(tick_of(1, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 16'sd0), 0);
        send_tick(tick_of(1, 8'h00, 0, 0, 0, 0, 0, 0, 0, 16'sd0), 0);
        // auto: swing-up, capture, crash back to swing-up
        send_tick(tick_of(0, 8'h00, 1, 0, 0, 0, 0, 0, 0, 16'sd4000), 0);
        send_tick(tick_of(0, 8'h00, 0, 0, 0, 0, 0, 0, 0, 16'sd0), 0);
        send_tick(tick_of(0, 8'h00, 0, 0, 0, 0, 0, 0, 0, 16'sh7FFF), 0);
        // assist: most negative angle never captures, override with and without link
        send_tick(tick_of(0, 8'h00, 0, 1, 0, 0, 0, 0, 0, 16'sh8000), 0);
        send_tick(tick_of(0, 8'h00, 0, 0, 0, 0, 0, 0, 0, 16'sd100), 0);
        send_tick(tick_of(0, 8'h00, 0, 0, 0, 0, 0, 1, 1, -16'sd200), 0);
        send_tick(tick_of(0, 8'h00, 0, 0, 0, 0, 0, 1, 0, -16'sd200), 0);
        send_tick(tick_of(0, 8'h00, 0, 0, 0, 0, 0, 0, 1, 16'sh8000), 0);
        // joystick mode and capture in one tick, then crash to idle
        send_tick(tick_of(0, 8'h00, 0, 0, 1, 0, 0, 0, 0, 16'sd0), 0);
        send_tick(tick_of(0, 8'h00, 0, 0, 0, 0, 0, 0, 0, 16'sd7000), 0);
        // several events in one tick, then emergency stop
        send_tick(tick_of(1, CMD_SWING, 1, 0, 0, 0, 0, 0, 0, 16'sd0), 0);
        send_tick(tick_of(0, 8'h00, 0, 0, 0, 0, 1, 1, 0, 16'sd0), 0);
        send_tick(tick_of(1, CMD_START, 1, 1, 1, 1, 1, 1, 1, 16'sh7FFF), 0);
        // exact limit values: no capture at the limit, no crash at the limit
        send_tick(tick_of(0, 8'h00, 0, 0, 1, 0, 0, 0, 0, 16'sd819), 0);
        send_tick(tick_of(0, 8'h00, 0, 0, 0, 0, 0, 0, 0, -16'sd818), 0);
        send_tick(tick_of(0, 8'h00, 0, 0, 0, 0, 0, 0, 0, 16'sd6434), 0);
        send_tick(tick_of(0, 8'h00, 0, 0, 0, 0, 0, 0, 0, -16'sd6435), 0);

        // random phases, one limit setting each
        for (ph = 0; ph < 7; ph++)
        begin
            case (ph)
                1:       write_limits(15'd0, 15'd32767);
                2:       write_limits(15'd32767, 15'd0);
                3:       write_limits(LIMIT_W'($urandom()), LIMIT_W'($urandom()));
                4:       write_limits(15'd1, 15'd32766);
                5:       write_limits(15'd4096, 15'd8192);
                6:       write_limits(LIMIT_W'($urandom()), LIMIT_W'($urandom()));
                default: ;
            endcase
            repeat (147)
                send_tick(random_tick(), !(accepted >= 400 && accepted < 600));
        end

        // wait for outstanding results, bounded
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (pending == 0 && fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #2400000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: pendulum_mode_supervisor_core.f
rtl/core/pms_pkg.sv
rtl/core/pms_in_reg.sv
rtl/core/pms_decide.sv
rtl/core/pms_out_reg.sv
rtl/core/pendulum_mode_supervisor_core.sv
tb/mode_supervisor_checker.sv
tb/tb.sv
